// ===== src/dtsp_pkg.sv =====
package dtsp_pkg;

    // number of fraction digits weighted into the microsecond total
    localparam int FRACTION_DIGITS = 6;
    localparam int SEEN_W          = $clog2(FRACTION_DIGITS + 1);

    // classified item queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // seconds overflow limits: 4294967295 = 429496729 * 10 + 5
    localparam logic [31:0] SEC_PREFIX_LIMIT = 32'd429496729;
    localparam logic [3:0]  MAX_LAST_DIGIT   = 4'd5;

    localparam logic [7:0] CHAR_NUL   = 8'h00;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_INVALID  = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        K_DIGIT = 2'd0,
        K_POINT = 2'd1,
        K_NUL   = 2'd2,
        K_OTHER = 2'd3
    } t_kind;

    typedef struct packed {
        logic [7:0] character;
        logic       last_char;
    } t_in_item;

    typedef struct packed {
        logic [31:0] seconds;
        logic [19:0] microseconds;
        logic [1:0]  status;
    } t_out_item;

    // one classified character
    typedef struct packed {
        t_kind      kind;
        logic [3:0] digit;
        logic       last;
    } t_cls;

    typedef struct packed {
        logic push;
        t_cls cls;
    } t_push;

    typedef struct packed {
        logic full;
        logic empty;
    } t_q_stat;

    // weight of a fraction digit, 10^k
    function automatic logic [31:0] pow_ten(input logic [3:0] k);
        logic [31:0] p;
        unique case (k)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            default: p = 32'd100000000;
        endcase
        return p;
    endfunction

endpackage

// ===== src/dtsp_front.sv =====
module dtsp_front import dtsp_pkg::*; (
    input  logic     i_valid,
    input  t_in_item i_item,
    input  t_q_stat  i_q_stat,
    output logic     o_stall,
    output t_push    o_push
);

    logic w_is_digit;
    t_cls w_cls;

    assign w_is_digit = (i_item.character >= CHAR_ZERO) && (i_item.character <= CHAR_NINE);

    // classify the byte
    always_comb begin
        w_cls.last  = i_item.last_char;
        w_cls.digit = 4'(i_item.character - CHAR_ZERO);
        if (w_is_digit) begin
            w_cls.kind = K_DIGIT;
        end else if (i_item.character == CHAR_POINT) begin
            w_cls.kind = K_POINT;
        end else if (i_item.character == CHAR_NUL) begin
            w_cls.kind = K_NUL;
        end else begin
            w_cls.kind = K_OTHER;
        end
    end

    assign o_stall     = i_q_stat.full;
    assign o_push.push = i_valid && !i_q_stat.full;
    assign o_push.cls  = w_cls;

endmodule

// ===== src/dtsp_queue.sv =====
module dtsp_queue import dtsp_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_push   i_push,
    input  logic    i_pop,
    output t_cls    o_head,
    output t_q_stat o_stat
);

    t_cls              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;
    logic [QCNT_W-1:0] n_cnt;

    always_comb begin
        n_cnt = r_cnt;
        if (i_push.push && !i_pop) begin
            n_cnt = r_cnt + QCNT_W'(1);
        end else if (!i_push.push && i_pop) begin
            n_cnt = r_cnt - QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push.push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr] <= i_push.cls;
        end
    end

    assign o_head       = r_mem[r_rd];
    assign o_stat.full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_stat.empty = (r_cnt == '0);

endmodule

// ===== src/dtsp_back.sv =====
module dtsp_back import dtsp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_cls      i_head,
    input  t_q_stat   i_q_stat,
    input  logic      i_out_stall,
    output logic      o_pop,
    output logic      o_out_valid,
    output t_out_item o_out_item
);

    typedef enum logic [2:0] {
        PH_INT  = 3'b001,
        PH_FRAC = 3'b010,
        PH_DROP = 3'b100
    } t_phase;

    t_phase            r_phase, n_phase;
    logic [31:0]       r_sec, n_sec;
    logic [19:0]       r_usec, n_usec;
    logic [SEEN_W-1:0] r_seen, n_seen;
    logic              r_out_valid;
    t_out_item         r_out_item;

    logic              w_emit;
    t_status           w_status;
    logic [31:0]       w_sec_next;
    logic [SEEN_W-1:0] w_k;
    logic [31:0]       w_prod;
    logic              w_ovf;
    logic [31:0]       w_ok_sec;
    logic [19:0]       w_ok_usec;

    // free output slot, or one being taken this cycle
    assign o_pop = !i_q_stat.empty && (!r_out_valid || !i_out_stall);

    assign w_sec_next = (r_sec << 3) + (r_sec << 1) + {28'd0, i_head.digit};
    assign w_ovf      = (r_sec > SEC_PREFIX_LIMIT) ||
                        ((r_sec == SEC_PREFIX_LIMIT) && (i_head.digit > MAX_LAST_DIGIT));
    assign w_k        = SEEN_W'(FRACTION_DIGITS - 1) - r_seen;
    assign w_prod     = {28'd0, i_head.digit} * pow_ten(4'(w_k));

    always_comb begin
        n_phase  = r_phase;
        n_sec    = r_sec;
        n_usec   = r_usec;
        n_seen   = r_seen;
        w_emit   = 1'b0;
        w_status = ST_OK;
        if (o_pop) begin
            unique case (r_phase)
                PH_INT, PH_FRAC: begin
                    if (i_head.kind == K_NUL) begin
                        w_emit = 1'b1;
                    end else if (r_phase == PH_INT) begin
                        unique case (i_head.kind)
                            K_DIGIT: begin
                                if (w_ovf) begin
                                    w_emit   = 1'b1;
                                    w_status = ST_OVERFLOW;
                                end else begin
                                    n_sec = w_sec_next;
                                end
                            end
                            K_POINT: n_phase = PH_FRAC;
                            default: begin
                                w_emit   = 1'b1;
                                w_status = ST_INVALID;
                            end
                        endcase
                    end else begin
                        if (i_head.kind == K_DIGIT) begin
                            if (r_seen < SEEN_W'(FRACTION_DIGITS)) begin
                                n_usec = r_usec + w_prod[19:0];
                                n_seen = r_seen + SEEN_W'(1);
                            end
                        end else begin
                            w_emit   = 1'b1;
                            w_status = ST_INVALID;
                        end
                    end
                    if (!w_emit && i_head.last) begin
                        w_emit = 1'b1;
                    end
                end
                default: begin
                    if (i_head.last) begin
                        n_phase = PH_INT;
                    end
                end
            endcase
        end
        if (w_emit) begin
            n_phase = i_head.last ? PH_INT : PH_DROP;
            n_sec   = '0;
            n_usec  = '0;
            n_seen  = '0;
        end
    end

    // values reported on an ok result include the digit consumed this cycle
    always_comb begin
        w_ok_sec  = r_sec;
        w_ok_usec = r_usec;
        if (r_phase == PH_INT && i_head.kind == K_DIGIT) begin
            w_ok_sec = w_sec_next;
        end
        if (r_phase == PH_FRAC && i_head.kind == K_DIGIT &&
            r_seen < SEEN_W'(FRACTION_DIGITS)) begin
            w_ok_usec = r_usec + w_prod[19:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_INT;
            r_sec       <= '0;
            r_usec      <= '0;
            r_seen      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_sec   <= n_sec;
            r_usec  <= n_usec;
            r_seen  <= n_seen;
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_item.status       <= w_status;
            r_out_item.seconds      <= (w_status == ST_OK) ? w_ok_sec : 32'd0;
            r_out_item.microseconds <= (w_status == ST_OK) ? w_ok_usec : 20'd0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

// ===== src/decimal_time_string_parser.sv =====
// decimal time string parser: ascii "<seconds>[.<fraction>]" to seconds and microseconds
// input channel: one byte per item on i_in_item.character, i_in_item.last_char set on
//   the final byte of a string; taken when i_in_valid is high and o_in_stall is low
// output channel: one result per string on o_out_item (seconds, microseconds, status);
//   taken when o_out_valid is high and i_out_stall is low
// status 0 ok, 1 seconds above 4294967295, 2 bad character; seconds and
//   microseconds read zero on an error status
// a string ends at a nul byte, a flagged last byte, a bad character or overflow;
//   bytes after an early end are dropped up to the flagged last byte
// the byte that ends a string is written to the queue at the edge that takes it;
//   its result is registered on the output when the back end pops that byte
// throughput: one byte per cycle unless a held result stalls the back-end update
//   (shift-add by ten for seconds, table weight times digit for the fraction)
// a four-item queue sits between classifier and back end; o_in_stall rises only
//   when that queue is full, so a stalled receiver fills the queue before the
//   sender is held
// reset (synchronous, active low): queue emptied, no result pending, accumulators
//   zero, parse restarts in the integer part
module decimal_time_string_parser import dtsp_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_item,
    output logic      o_in_stall,
    output logic      o_out_valid,
    input  logic      i_out_stall,
    output t_out_item o_out_item
);

    t_push   w_push;
    t_cls    w_head;
    t_q_stat w_q_stat;
    logic    w_pop;

    // front: handshake and byte classification
    dtsp_front u_front (
        .i_valid  (i_in_valid),
        .i_item   (i_in_item),
        .i_q_stat (w_q_stat),
        .o_stall  (o_in_stall),
        .o_push   (w_push)
    );

    // short queue of classified bytes
    dtsp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_pop   (w_pop),
        .o_head  (w_head),
        .o_stat  (w_q_stat)
    );

    // back: parse state, accumulators and result register
    dtsp_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .i_q_stat    (w_q_stat),
        .i_out_stall (i_out_stall),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

    // an accepted byte is in the queue on the next cycle
    a_push_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> !w_q_stat.empty)
        else $error("accepted byte missing from queue");

    // no pop from an empty queue
    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_q_stat.empty)
        else $error("pop from empty queue");

    // error results carry zero payload
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.status != ST_OK)) |->
        ((o_out_item.seconds == 32'd0) && (o_out_item.microseconds == 20'd0)))
        else $error("error result with non-zero fields");

    // status code three never produced
    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_item.status != 2'd3))
        else $error("undefined status code");

endmodule
